>>> rtl/core/sha256h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256h_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256h_pkg;

  localparam int unsigned BLK_BITS = 512;
  localparam int unsigned LEN_BITS = 64;

  // byte source for a buffer push
  localparam logic [1:0] SEL_IN   = 2'd0;
  localparam logic [1:0] SEL_80   = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  localparam logic [31:0] INIT_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       push;
    logic [1:0] byte_sel;
    logic       start_blk;
    logic       round_en;
    logic       final_add;
    logic       out_en;
    logic       clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       rnd_last;
    logic       out_last;
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] v);
    big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] v);
    big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] v);
    sml_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] v);
    sml_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

>>> rtl/core/sha256h_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256h_dp
// Datapath: block shift buffer, message schedule window, round unit,
// hash words, fill and length counters, digest word select.
// ----------------------------------------------------------------------------
module sha256h_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha256h_pkg::ctrl_cmd_t cmd,
  input  logic [7:0]             in_data_byte,
  output sha256h_pkg::dp_stat_t  stat,
  output logic [31:0]            out_digest_word,
  output logic [2:0]             out_word_index
);

  logic [sha256h_pkg::BLK_BITS-1:0] blk_r, blk_nxt;
  logic [sha256h_pkg::LEN_BITS-1:0] len_r, len_nxt, len_shl;
  logic [31:0] hash_r [0:7];
  logic [31:0] hash_nxt [0:7];
  logic [31:0] work_r [0:7];
  logic [31:0] work_nxt [0:7];
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  push_byte;
  logic [31:0] w_cur, w_new, t1, t2;

  assign len_shl = len_r << {fill_r[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      sha256h_pkg::SEL_IN:   push_byte = in_data_byte;
      sha256h_pkg::SEL_80:   push_byte = sha256h_pkg::PAD_BYTE;
      sha256h_pkg::SEL_ZERO: push_byte = 8'h00;
      sha256h_pkg::SEL_LEN:  push_byte = len_shl[63:56];
      default:               push_byte = 8'h00;
    endcase
  end

  // schedule window: word 0 sits at the top of the buffer
  assign w_cur = blk_r[511:480];
  assign w_new = sha256h_pkg::sml_sig1(blk_r[511-32*14 -: 32]) + blk_r[511-32*9 -: 32]
               + sha256h_pkg::sml_sig0(blk_r[479:448]) + blk_r[511:480];

  assign t1 = work_r[7] + sha256h_pkg::big_sig1(work_r[4])
            + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
            + sha256h_pkg::ROUND_K[rnd_r] + w_cur;
  assign t2 = sha256h_pkg::big_sig0(work_r[0])
            + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));

  always_comb begin
    blk_nxt  = blk_r;
    len_nxt  = len_r;
    fill_nxt = fill_r;
    rnd_nxt  = rnd_r;
    idx_nxt  = idx_r;
    for (int i = 0; i < 8; i++) begin
      hash_nxt[i] = hash_r[i];
      work_nxt[i] = work_r[i];
    end
    if (cmd.push) begin
      blk_nxt  = {blk_r[sha256h_pkg::BLK_BITS-9:0], push_byte};
      fill_nxt = fill_r + 6'd1;
      if (cmd.byte_sel == sha256h_pkg::SEL_IN) begin
        len_nxt = len_r + 64'd8;
      end
    end
    if (cmd.start_blk) begin
      rnd_nxt = 6'd0;
      for (int i = 0; i < 8; i++) begin
        work_nxt[i] = hash_r[i];
      end
    end
    if (cmd.round_en) begin
      blk_nxt     = {blk_r[479:0], w_new};
      rnd_nxt     = rnd_r + 6'd1;
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end
    if (cmd.final_add) begin
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = hash_r[i] + work_r[i];
      end
    end
    if (cmd.out_en) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (cmd.clear) begin
      len_nxt  = '0;
      fill_nxt = '0;
      for (int i = 0; i < 8; i++) begin
        hash_nxt[i] = sha256h_pkg::INIT_HASH[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      fill_r <= '0;
      rnd_r  <= '0;
      idx_r  <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha256h_pkg::INIT_HASH[i];
      end
    end else begin
      len_r  <= len_nxt;
      fill_r <= fill_nxt;
      rnd_r  <= rnd_nxt;
      idx_r  <= idx_nxt;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    for (int i = 0; i < 8; i++) begin
      work_r[i] <= work_nxt[i];
    end
  end

  assign stat.fill      = fill_r;
  assign stat.rnd_last  = (rnd_r == 6'd63);
  assign stat.out_last  = (idx_r == 3'd7);
  assign out_digest_word = hash_r[idx_r];
  assign out_word_index  = idx_r;

endmodule

>>> rtl/core/sha256h_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256h_ctrl
// Controller: byte intake, padding sequence, compression rounds and
// digest output.
// ----------------------------------------------------------------------------
module sha256h_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_byte_present,
  input  logic                   in_end_of_message,
  input  sha256h_pkg::dp_stat_t  stat,
  output sha256h_pkg::ctrl_cmd_t cmd,
  output logic                   busy,
  output logic                   out_valid,
  output logic                   out_last_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       pad_r, pad_nxt;
  logic       sent80_r, sent80_nxt;
  logic       lenph_r, lenph_nxt;

  always_comb begin
    state_nxt  = state_r;
    pad_nxt    = pad_r;
    sent80_nxt = sent80_r;
    lenph_nxt  = lenph_r;
    cmd        = '0;
    cmd.byte_sel = sha256h_pkg::SEL_IN;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          pad_nxt = in_end_of_message;
          if (in_byte_present) begin
            cmd.push = 1'b1;
          end
          if (in_byte_present && stat.fill == sha256h_pkg::FILL_LAST) begin
            cmd.start_blk = 1'b1;
            state_nxt     = ST_ROUND;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        if (!sent80_r) begin
          cmd.byte_sel = sha256h_pkg::SEL_80;
          sent80_nxt   = 1'b1;
        end else if (lenph_r || stat.fill == sha256h_pkg::LEN_START) begin
          cmd.byte_sel = sha256h_pkg::SEL_LEN;
          lenph_nxt    = 1'b1;
        end else begin
          cmd.byte_sel = sha256h_pkg::SEL_ZERO;
        end
        if (stat.fill == sha256h_pkg::FILL_LAST) begin
          cmd.start_blk = 1'b1;
          state_nxt     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.rnd_last) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.final_add = 1'b1;
        if (lenph_r) begin
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        cmd.out_en = 1'b1;
        if (stat.out_last) begin
          cmd.clear  = 1'b1;
          pad_nxt    = 1'b0;
          sent80_nxt = 1'b0;
          lenph_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pad_r    <= 1'b0;
      sent80_r <= 1'b0;
      lenph_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pad_r    <= pad_nxt;
      sent80_r <= sent80_nxt;
      lenph_r  <= lenph_nxt;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_last_word = (state_r == ST_OUT) && stat.out_last;

endmodule

>>> rtl/core/sha256_byte_stream_hasher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// SHA-256 over a byte stream; emits the digest as eight words per message.
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   in       | start / busy     | in_data_byte, in_byte_present,
//            |                  | in_end_of_message
//   out      | out_valid strobe | out_digest_word, out_word_index,
//            |                  | out_last_word
//
// A byte beat is accepted while idle as the block buffer fills; the beat that
// completes a 64-byte block starts the round unit (64 rounds, then one hash
// add), which holds busy high. An end-of-message beat adds the padding
// bytes, the compressions it triggers, and the eight output words. Synchronous
// reset loads the initial hash words. Outputs cannot be stalled.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256h_pkg::ctrl_cmd_t cmd;
  sha256h_pkg::dp_stat_t  stat;

  sha256h_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .stat              (stat),
    .cmd               (cmd),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_last_word     (out_last_word)
  );

  sha256h_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_data_byte),
    .stat            (stat),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the SHA-256 byte stream hasher against a behavioral SHA-256 kept in
// the bench. Messages go in one byte per beat, either closed on their last
// byte or by a bare end marker, with idle beats mixed in. Every digest word
// is compared against the predicted one, in order. Messages include the
// empty one and lengths around the padding boundaries.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF  = 6;
  localparam int N_ITEMS   = 500;
  localparam int LIMIT     = 400000;
  localparam int IDLE_PCT  = 38;
  localparam int CALM_LO   = 200;
  localparam int CALM_HI   = 330;
  localparam int TAIL_CYC  = 300;
  localparam int MAX_SHOWN = 10;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    bit         drain;
  } msg_beat_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  msg_beat_t    beat_q [$];
  digest_beat_t digest_q [$];
  msg_beat_t    offered;

  logic [31:0] hash_h [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  int items_made = 0;
  int n_fired = 0;
  int msgs_done = 0;
  int words_due = 0;
  int words_rcvd = 0;
  int mismatches = 0;
  int cyc = 0;

  sha256_byte_stream_hasher_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void hash_clear();
    for (int k = 0; k < 8; k++) hash_h[k] = SHA_IV[k];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    for (int k = 0; k < 8; k++) v[k] = hash_h[k];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) hash_h[k] = hash_h[k] + v[k];
  endfunction

  function automatic void blk_push(input logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill++;
    if (blk_fill == 64) begin
      sha_compress();
      blk_fill = 0;
    end
  endfunction

  function automatic void sha_absorb(input msg_beat_t b);
    logic [63:0]  total;
    digest_beat_t db;
    if (b.present) begin
      msg_bits = msg_bits + 64'd8;
      blk_push(b.data);
    end
    if (b.eom) begin
      total = msg_bits;
      blk_push(8'h80);
      while (blk_fill != 56) blk_push(8'h00);
      for (int k = 0; k < 8; k++) blk_push(total[63 - 8*k -: 8]);
      for (int k = 0; k < 8; k++) begin
        db.word = hash_h[k];
        db.idx  = 3'(k);
        db.last = (k == 7);
        digest_q.push_back(db);
      end
      msgs_done++;
      hash_clear();
    end
  endfunction

  function automatic void note_fail(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0t] %s", $realtime, msg);
  endfunction

  function automatic void queue_beat(input logic [7:0] d, input logic p, input logic e,
                                     input bit dr);
    msg_beat_t b;
    b.data    = d;
    b.present = p;
    b.eom     = e;
    b.drain   = dr;
    beat_q.push_back(b);
    if (p || e) items_made++;
  endfunction

  function automatic void queue_message(input int nb, input bit dr);
    bit tail_eom;
    bit pend_dr;
    tail_eom = (nb > 0) && ($urandom_range(1) == 1);
    pend_dr  = dr;
    for (int i = 0; i < nb; i++) begin
      if ($urandom_range(99) < 8) begin
        queue_beat(8'($urandom), 1'b0, 1'b0, pend_dr);
        pend_dr = 1'b0;
      end
      queue_beat(8'($urandom), 1'b1, tail_eom && (i == nb - 1), pend_dr);
      pend_dr = 1'b0;
    end
    if (!tail_eom) queue_beat(8'($urandom), 1'b0, 1'b1, pend_dr);
  endfunction

  // driver: offer one beat at a time, hold it until busy drops
  always @(posedge clk) begin
    bit fire;
    bit idle;
    bit drained;
    fire = start && !busy;
    if (fire) begin
      sha_absorb(offered);
      n_fired++;
      if (offered.eom) words_due <= words_due + 8;
    end
    idle = (n_fired < CALM_LO || n_fired >= CALM_HI) && ($urandom_range(99) < IDLE_PCT);
    drained = !start && (words_due == words_rcvd + out_valid);
    if (start && !fire) begin
    end else if (rst_n && beat_q.size() != 0 && !idle && (!beat_q[0].drain || drained))
    begin
      offered = beat_q.pop_front();
      start             <= 1'b1;
      in_data_byte      <= offered.data;
      in_byte_present   <= offered.present;
      in_end_of_message <= offered.eom;
    end else begin
      start             <= 1'b0;
      in_data_byte      <= 8'($urandom);
      in_byte_present   <= 1'($urandom);
      in_end_of_message <= 1'($urandom);
    end
  end

  // monitor: compare each digest word with the oldest prediction
  always @(posedge clk) begin
    digest_beat_t exp_b;
    if (rst_n && out_valid) begin
      words_rcvd <= words_rcvd + 1;
      if (digest_q.size() == 0) begin
        note_fail($sformatf("unexpected digest word %h idx %0d last %b",
                            out_digest_word, out_word_index, out_last_word));
      end else begin
        exp_b = digest_q.pop_front();
        if (out_digest_word !== exp_b.word || out_word_index !== exp_b.idx ||
            out_last_word !== exp_b.last) begin
          note_fail($sformatf("digest beat exp %h/%0d/%b got %h/%0d/%b",
                              exp_b.word, exp_b.idx, exp_b.last,
                              out_digest_word, out_word_index, out_last_word));
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int edge_lens [9];
    int len;
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    hash_clear();

    // empty message, idle beat, short messages, byte extremes
    queue_beat(8'hff, 1'b0, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b0, 1'b0);
    queue_beat(8'h61, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h62, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b1, 1'b0, 1'b1);
    queue_beat(8'hff, 1'b1, 1'b0, 1'b0);
    queue_beat(8'h5a, 1'b0, 1'b1, 1'b0);
    queue_beat(8'h80, 1'b1, 1'b1, 1'b0);
    queue_beat(8'hff, 1'b1, 1'b1, 1'b0);

    queue_message(130, 1'b1);
    while (items_made < N_ITEMS) begin
      if ($urandom_range(99) < 20) len = edge_lens[$urandom_range(8)];
      else len = $urandom_range(16);
      queue_message(len, $urandom_range(7) == 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (beat_q.size() != 0 || start) @(negedge clk);
    while (words_due != words_rcvd) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);

    if (digest_q.size() != 0)
      note_fail($sformatf("%0d digest words never arrived", digest_q.size()));

    $display("hashed %0d messages from %0d beats, incl. empty and pad-boundary lengths",
             msgs_done, n_fired);
    $display("%0d digest words compared, %0d mismatches", words_rcvd, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
